@@ hdl/pbi_pkg.sv @@
// Shared types and constants for the pairwise barycentric interpolator.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package pbi_pkg;

  localparam int GRID_SIDE        = 256;
  localparam int ENTRY_BITS       = 16;
  localparam int WEIGHT_FRAC_BITS = 15;
  localparam int TRI_VERTS        = 3;

  localparam int MODE_W   = 2;
  localparam int IDX_W    = 8;
  localparam int WEIGHT_W = 16;
  localparam int VALUE_W  = 16;
  localparam int RESULT_W = 16;

  localparam int VERT_W    = $clog2(TRI_VERTS);
  localparam int MEM_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int WW_W      = 2 * WEIGHT_W;
  localparam int PROD_W    = WW_W + 1 + ENTRY_BITS;
  localparam int ACC_W     = PROD_W + 4;
  localparam int SHIFT     = 2 * WEIGHT_FRAC_BITS;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_ROW   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } ctrl_state_e;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     addr;
    logic [ENTRY_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic                vld;
    logic                first;
    logic                last;
    logic                zero;
    logic [WEIGHT_W-1:0] row_w;
    logic [WEIGHT_W-1:0] col_w;
  } term_t;

endpackage

`default_nettype wire

@@ hdl/pbi_matrix_ram.sv @@
// Single-port matrix store, one access per cycle, registered read data.
// Depends on pbi_pkg for depth and entry width.
`default_nettype none

module pbi_matrix_ram (
  input  wire logic                          clk_i,
  input  wire pbi_pkg::mem_req_t             req_i,
  output logic [pbi_pkg::ENTRY_BITS-1:0]     rdata_o
);
  import pbi_pkg::*;

  logic [ENTRY_BITS-1:0] mem [MEM_DEPTH];
  logic [ENTRY_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/pbi_mac.sv @@
// Term pipeline: weight product, entry product, accumulate, shift and saturate.
// Depends on pbi_pkg; the entry arrives from pbi_matrix_ram in the cycle after issue.
`default_nettype none

module pbi_mac (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pbi_pkg::term_t                term_i,
  input  wire logic [pbi_pkg::ENTRY_BITS-1:0] entry_i,
  input  wire logic                          res_take_i,
  output logic                               res_valid_o,
  output logic [pbi_pkg::RESULT_W-1:0]       result_o
);
  import pbi_pkg::*;

  // stage 1: weight product, aligned with the memory read
  logic            s1_vld_q, s1_first_q, s1_last_q, s1_zero_q;
  logic [WW_W-1:0] ww_q;
  // stage 2: entry product
  logic                     s2_vld_q, s2_first_q, s2_last_q;
  logic signed [PROD_W-1:0] prod_q;
  // stage 3: accumulator
  logic signed [ACC_W-1:0]  acc_q;
  logic                     res_valid_q;

  logic signed [ENTRY_BITS-1:0] entry;
  logic signed [ACC_W-1:0]      shifted;
  logic                         no_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s1_first_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s1_zero_q   <= 1'b0;
      s2_vld_q    <= 1'b0;
      s2_first_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_vld_q   <= term_i.vld;
      s1_first_q <= term_i.first;
      s1_last_q  <= term_i.last;
      s1_zero_q  <= term_i.zero;
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      if (s2_vld_q && s2_last_q) begin
        res_valid_q <= 1'b1;
      end else if (res_take_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign entry = s1_zero_q ? '0 : $signed(entry_i);

  always_ff @(posedge clk_i) begin
    ww_q   <= WW_W'(term_i.row_w) * WW_W'(term_i.col_w);
    prod_q <= PROD_W'($signed({1'b0, ww_q})) * PROD_W'(entry);
    if (s2_vld_q) begin
      acc_q <= s2_first_q ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  // floor shift, then saturate to the entry width
  assign shifted = acc_q >>> SHIFT;
  assign no_ovf  = (&shifted[ACC_W-1:ENTRY_BITS-1]) || !(|shifted[ACC_W-1:ENTRY_BITS-1]);

  always_comb begin
    if (no_ovf) begin
      result_o = RESULT_W'(shifted[ENTRY_BITS-1:0]);
    end else if (shifted[ACC_W-1]) begin
      result_o = RESULT_W'({1'b1, {(ENTRY_BITS-1){1'b0}}});
    end else begin
      result_o = RESULT_W'({1'b0, {(ENTRY_BITS-1){1'b1}}});
    end
  end

  assign res_valid_o = res_valid_q;

endmodule

`default_nettype wire

@@ hdl/pbi_ctrl.sv @@
// Input sequencer: loads, row triangle registers, nine-read query walk.
// Depends on pbi_pkg; drives the matrix store port and the term pipeline.
`default_nettype none

module pbi_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [pbi_pkg::MODE_W-1:0]    mode_i,
  input  wire logic [pbi_pkg::IDX_W-1:0]     index_0_i,
  input  wire logic [pbi_pkg::IDX_W-1:0]     index_1_i,
  input  wire logic [pbi_pkg::IDX_W-1:0]     index_2_i,
  input  wire logic [pbi_pkg::WEIGHT_W-1:0]  weight_0_i,
  input  wire logic [pbi_pkg::WEIGHT_W-1:0]  weight_1_i,
  input  wire logic [pbi_pkg::WEIGHT_W-1:0]  weight_2_i,
  input  wire logic [pbi_pkg::VALUE_W-1:0]   value_i,
  input  wire logic                          res_take_i,
  output pbi_pkg::mem_req_t                  mem_req_o,
  output pbi_pkg::term_t                     term_o
);
  import pbi_pkg::*;

  localparam logic [VERT_W-1:0] LAST_VERT = VERT_W'(TRI_VERTS - 1);

  ctrl_state_e state_q, state_d;
  logic [VERT_W-1:0] ra_q, cb_q;

  logic [IDX_W-1:0]    row_idx_q [TRI_VERTS];
  logic [WEIGHT_W-1:0] row_w_q   [TRI_VERTS];
  logic [IDX_W-1:0]    col_idx_q [TRI_VERTS];
  logic [WEIGHT_W-1:0] col_w_q   [TRI_VERTS];

  logic        accept, walk_end, load_ok, vert_ok;
  mode_e       mode;
  logic [IDX_W-1:0] row_sel, col_sel;

  assign mode     = mode_e'(mode_i);
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign walk_end = (ra_q == LAST_VERT) && (cb_q == LAST_VERT);
  assign load_ok  = (32'(index_0_i) < GRID_SIDE) && (32'(index_1_i) < GRID_SIDE);
  assign row_sel  = row_idx_q[ra_q];
  assign col_sel  = col_idx_q[cb_q];
  assign vert_ok  = (32'(row_sel) < GRID_SIDE) && (32'(col_sel) < GRID_SIDE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (mode == MODE_QUERY)) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (walk_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (res_take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    term_o.vld   = (state_q == ST_RUN);
    term_o.first = (ra_q == '0) && (cb_q == '0);
    term_o.last  = walk_end;
    term_o.zero  = !vert_ok;
    term_o.row_w = row_w_q[ra_q];
    term_o.col_w = col_w_q[cb_q];
    mem_req_o.wdata = ENTRY_BITS'($signed(value_i));
    if (accept && (mode == MODE_LOAD) && load_ok) begin
      mem_req_o.we   = 1'b1;
      mem_req_o.addr = ADDR_W'(32'(index_0_i) * GRID_SIDE + 32'(index_1_i));
    end else begin
      mem_req_o.we   = 1'b0;
      mem_req_o.addr = ADDR_W'(32'(row_sel) * GRID_SIDE + 32'(col_sel));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ra_q    <= '0;
      cb_q    <= '0;
      for (int i = 0; i < TRI_VERTS; i++) begin
        row_idx_q[i] <= '0;
        row_w_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept && (mode == MODE_QUERY)) begin
        ra_q <= '0;
        cb_q <= '0;
      end else if (state_q == ST_RUN) begin
        if (cb_q == LAST_VERT) begin
          cb_q <= '0;
          ra_q <= walk_end ? '0 : ra_q + 1'b1;
        end else begin
          cb_q <= cb_q + 1'b1;
        end
      end
      if (accept && (mode == MODE_ROW)) begin
        row_idx_q[0] <= index_0_i;
        row_idx_q[1] <= index_1_i;
        row_idx_q[2] <= index_2_i;
        row_w_q[0]   <= weight_0_i;
        row_w_q[1]   <= weight_1_i;
        row_w_q[2]   <= weight_2_i;
      end
    end
  end

  // hold the column triangle for the walk
  always_ff @(posedge clk_i) begin
    if (accept && (mode == MODE_QUERY)) begin
      col_idx_q[0] <= index_0_i;
      col_idx_q[1] <= index_1_i;
      col_idx_q[2] <= index_2_i;
      col_w_q[0]   <= weight_0_i;
      col_w_q[1]   <= weight_1_i;
      col_w_q[2]   <= weight_2_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pairwise_barycentric_interp_top.sv @@
// Top level of the pairwise barycentric interpolator: sequencer, matrix store,
// term pipeline and output register. Depends on pbi_pkg, pbi_ctrl,
// pbi_matrix_ram and pbi_mac.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   in      | input     | in_valid_i / in_stall_o | mode, index_0..2, weight_0..2, value
//   out     | output    | out_valid_o / out_stall_i | result
//
// A load word or a row-triangle word leaves the input unstalled. A query word walks the
// nine row/column pairs, one matrix read per cycle on the single store port,
// then drains three pipeline stages; the input stalls until its result is taken.
// Reset clears the row triangle and all control; the matrix store is not cleared.
// A finished result waits in the output register while new words are taken; a
// later query holds in its drain state until that register frees up.
`default_nettype none

module pairwise_barycentric_interp_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [pbi_pkg::MODE_W-1:0]    mode_i,
  input  wire logic [pbi_pkg::IDX_W-1:0]     index_0_i,
  input  wire logic [pbi_pkg::IDX_W-1:0]     index_1_i,
  input  wire logic [pbi_pkg::IDX_W-1:0]     index_2_i,
  input  wire logic [pbi_pkg::WEIGHT_W-1:0]  weight_0_i,
  input  wire logic [pbi_pkg::WEIGHT_W-1:0]  weight_1_i,
  input  wire logic [pbi_pkg::WEIGHT_W-1:0]  weight_2_i,
  input  wire logic signed [pbi_pkg::VALUE_W-1:0] value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [pbi_pkg::RESULT_W-1:0] result_o
);
  import pbi_pkg::*;

  mem_req_t              mem_req;
  term_t                 term;
  logic [ENTRY_BITS-1:0] entry;
  logic                  res_valid, res_take;
  logic [RESULT_W-1:0]   res_value;

  logic                out_valid_q, out_valid_d;
  logic [RESULT_W-1:0] result_q;

  // Sequencer: accepts words, writes loads, walks the query pairs.
  pbi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .index_0_i  (index_0_i),
    .index_1_i  (index_1_i),
    .index_2_i  (index_2_i),
    .weight_0_i (weight_0_i),
    .weight_1_i (weight_1_i),
    .weight_2_i (weight_2_i),
    .value_i    (value_i),
    .res_take_i (res_take),
    .mem_req_o  (mem_req),
    .term_o     (term)
  );

  // Matrix store: loads and query reads never share a cycle.
  pbi_matrix_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (entry)
  );

  // Weight product, entry product, accumulate, then floor shift and saturate.
  pbi_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .term_i      (term),
    .entry_i     (entry),
    .res_take_i  (res_take),
    .res_valid_o (res_valid),
    .result_o    (res_value)
  );

  // Advance the result into the output register when it is empty or draining.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: load only on take, so a stalled word holds.
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      result_q <= res_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = $signed(result_q);

endmodule

`default_nettype wire
